[design/quoted_command_line_tokenizer_top_defines.svh]
// assertion macros for the checker file
`ifndef QUOTED_COMMAND_LINE_TOKENIZER_TOP_DEFINES_SVH
`define QUOTED_COMMAND_LINE_TOKENIZER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define QCLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define QCLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/qclt_pkg.sv]
`default_nettype none

package qclt_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_ARG_END  = 2'd1,
    KIND_LINE_OK  = 2'd2,
    KIND_LINE_ERR = 2'd3
  } qclt_kind_e;

  // open quote state
  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_DOUBLE = 2'd1,
    Q_SINGLE = 2'd2
  } qclt_quote_e;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  // one queued command: a result, plus a flag for a trailing line-end result
  typedef struct packed {
    qclt_kind_e  kind;
    logic [7:0]  char_out;
    logic [7:0]  arg_count;
    logic        line_end_follows;
  } qclt_entry_t;

  // queue status: full holds the input side, empty is seen by the back
  typedef struct packed {
    logic full;
    logic empty;
  } qclt_qstat_t;

endpackage

`default_nettype wire

[design/qclt_front.sv]
`default_nettype none

module qclt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          char_in_i,
  output logic                push_o,
  output qclt_pkg::qclt_entry_t push_entry_o
);
  import qclt_pkg::*;

  logic        between_q, between_d;
  qclt_quote_e quote_q, quote_d;
  logic [7:0]  args_q, args_d;

  logic        is_sp, is_nl, is_nul, is_dq, is_sq, blank;
  qclt_quote_e this_q;
  logic [7:0]  args_inc;
  logic        has_res;
  qclt_entry_t ent;

  assign is_sp    = (char_in_i == CH_SPACE) || (char_in_i == CH_TAB);
  assign is_nl    = (char_in_i == CH_NL);
  assign is_nul   = (char_in_i == CH_NUL);
  assign is_dq    = (char_in_i == CH_DQUOTE);
  assign is_sq    = (char_in_i == CH_SQUOTE);
  assign blank    = is_sp || is_nl || is_nul;
  assign this_q   = is_dq ? Q_DOUBLE : Q_SINGLE;
  assign args_inc = (args_q == COUNT_MAX) ? COUNT_MAX : args_q + 8'd1;

  always_comb begin
    between_d = between_q;
    quote_d   = quote_q;
    args_d    = args_q;
    has_res   = 1'b0;
    ent.kind             = KIND_BYTE;
    ent.char_out         = char_in_i;
    ent.arg_count        = args_q;
    ent.line_end_follows = 1'b0;

    if (between_q && is_sp) begin
      // space or tab before an argument, skipped
    end else if (between_q && is_nul) begin
      has_res      = 1'b1;
      ent.kind     = (quote_q != Q_NONE) ? KIND_LINE_ERR : KIND_LINE_OK;
      ent.char_out = CH_NUL;
      between_d    = 1'b1;
      quote_d      = Q_NONE;
      args_d       = '0;
    end else begin
      between_d = 1'b0;
      if (is_dq || is_sq) begin
        if (quote_q == this_q) begin
          quote_d = Q_NONE;
        end else if (quote_q == Q_NONE) begin
          quote_d = this_q;
        end else begin
          has_res = 1'b1;
        end
      end else if (!blank) begin
        has_res = 1'b1;
      end else if (quote_q == Q_NONE) begin
        // end of an unquoted argument
        has_res              = 1'b1;
        ent.kind             = KIND_ARG_END;
        ent.char_out         = CH_NUL;
        ent.arg_count        = args_inc;
        ent.line_end_follows = is_nul;
        between_d            = 1'b1;
        args_d               = is_nul ? 8'd0 : args_inc;
      end else if (is_nul) begin
        // line ends inside a quote, partial argument dropped
        has_res      = 1'b1;
        ent.kind     = KIND_LINE_ERR;
        ent.char_out = CH_NUL;
        between_d    = 1'b1;
        quote_d      = Q_NONE;
        args_d       = '0;
      end else begin
        has_res = 1'b1;
      end
    end
  end

  assign push_o       = accept_i && has_res;
  assign push_entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      between_q <= 1'b1;
      quote_q   <= Q_NONE;
      args_q    <= '0;
    end else if (accept_i) begin
      between_q <= between_d;
      quote_q   <= quote_d;
      args_q    <= args_d;
    end
  end

endmodule

`default_nettype wire

[design/qclt_queue.sv]
`default_nettype none

module qclt_queue #(
  parameter int Depth = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  qclt_pkg::qclt_entry_t push_entry_i,
  input  logic                  pop_i,
  output qclt_pkg::qclt_entry_t head_o,
  output qclt_pkg::qclt_qstat_t stat_o
);
  import qclt_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  qclt_entry_t    mem_q [Depth];
  logic [AW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    r = (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
    return r;
  endfunction

  always_comb begin
    wr_d  = push_i ? bump(wr_q) : wr_q;
    rd_d  = pop_i  ? bump(rd_q) : rd_q;
    cnt_d = cnt_q + CW'(push_i) - CW'(pop_i);
  end

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

[design/qclt_back.sv]
`default_nettype none

module qclt_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  qclt_pkg::qclt_entry_t head_i,
  input  qclt_pkg::qclt_qstat_t stat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            kind_o,
  output logic [7:0]            char_out_o,
  output logic [7:0]            arg_count_o,
  output logic                  last_o
);
  import qclt_pkg::*;

  logic       valid_q, valid_d;
  logic       pend_q, pend_d;
  qclt_kind_e kind_q, kind_d;
  logic [7:0] char_q, char_d;
  logic [7:0] count_q, count_d;
  logic       last_q, last_d;
  logic       load;

  assign load = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    pend_d  = pend_q;
    kind_d  = kind_q;
    char_d  = char_q;
    count_d = count_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (load) begin
      if (pend_q) begin
        // trailing line end, same count as the argument end before it
        valid_d = 1'b1;
        pend_d  = 1'b0;
        kind_d  = KIND_LINE_OK;
        char_d  = CH_NUL;
        last_d  = 1'b1;
      end else if (!stat_i.empty) begin
        pop_o   = 1'b1;
        valid_d = 1'b1;
        pend_d  = head_i.line_end_follows;
        kind_d  = head_i.kind;
        char_d  = head_i.char_out;
        count_d = head_i.arg_count;
        last_d  = !head_i.line_end_follows;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    char_q  <= char_d;
    count_q <= count_d;
    last_q  <= last_d;
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign char_out_o  = char_q;
  assign arg_count_o = count_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

[design/quoted_command_line_tokenizer_top.sv]
// channel  | handshake               | payload
// ---------+-------------------------+------------------------------------------
// in       | in_valid_i / in_stall_o | char_in_i
// out      | out_valid_o/out_stall_i | kind_o, char_out_o, arg_count_o, last_o
//
// one byte is taken per cycle while the command queue has room
// a byte gives zero, one or two results; the back end sends one result per cycle,
// unless out_stall_i holds it, so an argument end that also closes the line is
// sent as two results; each result passes through queue and output register
// reset clears tokenizer state, queue pointers and output valid; no clearing pass
// in_stall_o rises only when the queue is full
`default_nettype none

module quoted_command_line_tokenizer_top #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] char_out_o,
  output logic [7:0] arg_count_o,
  output logic       last_o
);
  import qclt_pkg::*;

  // front to queue
  logic        push;
  qclt_entry_t push_entry;
  // queue to back
  qclt_entry_t head;
  qclt_qstat_t qstat;
  logic        pop;
  logic        accept;

  // byte accepted whenever the queue can take a command
  assign in_stall_o = qstat.full;
  assign accept     = in_valid_i && !qstat.full;

  // classifier: tracks blank skipping, open quote and argument count
  qclt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .char_in_i    (char_in_i),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // short command queue decoupling classifier and result sender
  qclt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .stat_o       (qstat)
  );

  // result sender with output register, expands argument end plus line end
  qclt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .char_out_o  (char_out_o),
    .arg_count_o (arg_count_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

[design/qclt_checker.sv]
`default_nettype none
`include "quoted_command_line_tokenizer_top_defines.svh"

module qclt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] kind_o,
  input logic [7:0] char_out_o,
  input logic [7:0] arg_count_o,
  input logic       last_o
);
  import qclt_pkg::*;

  // a stalled result stays put
  `QCLT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(kind_o) && $stable(char_out_o) && $stable(arg_count_o) && $stable(last_o), "stalled result changed")

  // an argument byte is always the only result of its input byte
  `QCLT_ASSERT_NOW(a_byte_last, out_valid_o && (kind_o == KIND_BYTE), last_o, "argument byte without last")

  // an argument end that is not last is followed at once by a clean line end
  `QCLT_ASSERT_NEXT(a_pair, out_valid_o && !out_stall_i && (kind_o == KIND_ARG_END) && !last_o, out_valid_o && (kind_o == KIND_LINE_OK) && last_o, "missing line end after argument end")

  // only argument bytes carry a character
  `QCLT_ASSERT_NOW(a_char_zero, out_valid_o && (kind_o != KIND_BYTE), char_out_o == CH_NUL, "nonzero char on a marker result")

  // line results are always last
  `QCLT_ASSERT_NOW(a_line_last, out_valid_o && ((kind_o == KIND_LINE_OK) || (kind_o == KIND_LINE_ERR)), last_o, "line end not last")

endmodule

bind quoted_command_line_tokenizer_top qclt_checker u_qclt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .char_out_o  (char_out_o),
  .arg_count_o (arg_count_o),
  .last_o      (last_o)
);

`default_nettype wire

[dv/quoted_command_line_tokenizer_top_tb.sv]
`default_nettype none

module quoted_command_line_tokenizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qclt_pkg::*;

  // one result item as it leaves the block
  typedef struct packed {
    qclt_kind_e kind;
    logic [7:0] ch;
    logic [7:0] count;
    logic       last;
  } token_t;

  // one input item, with results typed in where they are plain to see
  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    logic [1:0] n_typed;
    token_t     t0;
    token_t     t1;
  } row_t;

  localparam int     RANDOM_ITEMS = 1100;
  localparam int     HOLD_CYCLES  = 80;
  localparam int     CYCLE_LIMIT  = 300000;
  localparam int     DRAIN_CYCLES = 8;
  localparam token_t TOK_NONE     = '0;
  localparam int     N_DIRECTED   = 27;

  // directed lines: empty line, plain words, byte extremes, quote errors,
  // empty quoted pair, newline between arguments, literals inside quotes
  localparam row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{CH_NUL,    1'b1, 2'd1, '{KIND_LINE_OK, CH_NUL, 8'd0, 1'b1}, TOK_NONE},
    '{"a",       1'b0, 2'd0, TOK_NONE, TOK_NONE},
    '{"b",       1'b0, 2'd0, TOK_NONE, TOK_NONE},
    '{CH_SPACE,  1'b0, 2'd0, TOK_NONE, TOK_NONE},
    '{CH_NUL,    1'b1, 2'd1, '{KIND_LINE_OK, CH_NUL, 8'd1, 1'b1}, TOK_NONE},
    '{8'hFF,     1'b1, 2'd1, '{KIND_BYTE, 8'hFF, 8'd0, 1'b1}, TOK_NONE},
    '{8'h01,     1'b1, 2'd1, '{KIND_BYTE, 8'h01, 8'd0, 1'b1}, TOK_NONE},
    '{CH_NUL,    1'b1, 2'd2, '{KIND_ARG_END, CH_NUL, 8'd1, 1'b0},
                             '{KIND_LINE_OK, CH_NUL, 8'd1, 1'b1}},
    '{CH_DQUOTE, 1'b0, 2'd0, TOK_NONE, TOK_NONE},
    '{"x",       1'b0, 2'd0, TOK_NONE, TOK_NONE},
    '{CH_NUL,    1'b1, 2'd1, '{KIND_LINE_ERR, CH_NUL, 8'd0, 1'b1}, TOK_NONE},
    '{CH_SQUOTE, 1'b0, 2'd0, TOK_NONE, TOK_NONE},
    '{CH_SQUOTE, 1'b0, 2'd0, TOK_NONE, TOK_NONE},
    '{CH_SPACE,  1'b0, 2'd0, TOK_NONE, TOK_NONE},
    '{CH_TAB,    1'b0, 2'd0, TOK_NONE, TOK_NONE},
    '{CH_NL,     1'b0, 2'd0, TOK_NONE, TOK_NONE},
    '{CH_DQUOTE, 1'b0, 2'd0, TOK_NONE, TOK_NONE},
    '{CH_SQUOTE, 1'b0, 2'd0, TOK_NONE, TOK_NONE},
    '{CH_SPACE,  1'b0, 2'd0, TOK_NONE, TOK_NONE},
    '{CH_TAB,    1'b0, 2'd0, TOK_NONE, TOK_NONE},
    '{CH_NL,     1'b0, 2'd0, TOK_NONE, TOK_NONE},
    '{CH_DQUOTE, 1'b0, 2'd0, TOK_NONE, TOK_NONE},
    '{"z",       1'b0, 2'd0, TOK_NONE, TOK_NONE},
    '{CH_NUL,    1'b0, 2'd0, TOK_NONE, TOK_NONE},
    '{CH_SQUOTE, 1'b0, 2'd0, TOK_NONE, TOK_NONE},
    '{CH_DQUOTE, 1'b0, 2'd0, TOK_NONE, TOK_NONE},
    '{CH_NUL,    1'b1, 2'd1, '{KIND_LINE_ERR, CH_NUL, 8'd0, 1'b1}, TOK_NONE}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] char_in_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] kind_o;
  logic [7:0] char_out_o;
  logic [7:0] arg_count_o;
  logic       last_o;

  quoted_command_line_tokenizer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .char_in_i  (char_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .kind_o     (kind_o),
    .char_out_o (char_out_o),
    .arg_count_o(arg_count_o),
    .last_o     (last_o)
  );

  row_t   line_bytes [$];
  token_t pending_tokens [$];
  int     fail_count = 0;
  int     accepted   = 0;
  int     cycles     = 0;
  bit     calm       = 1'b0;
  bit     hold_req   = 1'b0;

  // tokenizer state as the predictor sees it
  logic        skip_blanks;
  qclt_quote_e quote_open;
  logic [7:0]  args_seen;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // line-end result from the current state, then back to the start of a line
  function automatic token_t close_line();
    token_t t;
    t = '{KIND_LINE_OK, CH_NUL, args_seen, 1'b0};
    if (quote_open != Q_NONE) t.kind = KIND_LINE_ERR;
    skip_blanks = 1'b1;
    quote_open  = Q_NONE;
    args_seen   = '0;
    return t;
  endfunction

  // results of one byte, advancing the tokenizer state
  function automatic int tokenize_byte(input logic [7:0] c, output token_t t0,
                                       output token_t t1);
    token_t      t [2];
    qclt_quote_e q;
    logic        blank;
    int          n;
    t[0]  = TOK_NONE;
    t[1]  = TOK_NONE;
    n     = 0;
    blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_NUL);
    if (skip_blanks && (c == CH_SPACE || c == CH_TAB)) begin
      n = 0;
    end else if (skip_blanks && c == CH_NUL) begin
      t[0] = close_line();
      n = 1;
    end else begin
      skip_blanks = 1'b0;
      if (c == CH_DQUOTE || c == CH_SQUOTE) begin
        q = (c == CH_DQUOTE) ? Q_DOUBLE : Q_SINGLE;
        if (quote_open == q) begin
          quote_open = Q_NONE;
        end else if (quote_open == Q_NONE) begin
          quote_open = q;
        end else begin
          // the other quote kind is plain text inside a quote
          t[0] = '{KIND_BYTE, c, args_seen, 1'b0};
          n = 1;
        end
      end else if (!blank || (quote_open != Q_NONE && c != CH_NUL)) begin
        t[0] = '{KIND_BYTE, c, args_seen, 1'b0};
        n = 1;
      end else if (quote_open == Q_NONE) begin
        if (args_seen != COUNT_MAX) args_seen = args_seen + 8'd1;
        t[0] = '{KIND_ARG_END, CH_NUL, args_seen, 1'b0};
        n = 1;
        skip_blanks = 1'b1;
        if (c == CH_NUL) begin
          t[1] = close_line();
          n = 2;
        end
      end else begin
        // line ends inside a quote: partial argument dropped
        t[0] = close_line();
        n = 1;
      end
    end
    if (n > 0) t[n-1].last = 1'b1;
    t0 = t[0];
    t1 = t[1];
    return n;
  endfunction

  task automatic push_byte(input logic [7:0] c);
    line_bytes.push_back('{c, 1'b0, 2'd0, TOK_NONE, TOK_NONE});
  endtask

  // random byte of argument text, never zero and never the closing quote
  function automatic logic [7:0] text_byte(input logic [7:0] stop_ch, input bit plain);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255, 1));
    end while (c == stop_ch || (plain && (c == CH_SPACE || c == CH_TAB ||
               c == CH_NL || c == CH_DQUOTE || c == CH_SQUOTE)));
    return c;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_NL;
    endcase
  endfunction

  task automatic build_lines();
    int          base;
    int          pick;
    logic [7:0]  qc;
    bit          sat_done;
    base     = line_bytes.size();
    sat_done = 1'b0;
    while (line_bytes.size() - base < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (!sat_done && (line_bytes.size() - base >= 100)) begin
        // enough empty arguments to saturate the count
        sat_done = 1'b1;
        repeat (260) push_byte(CH_NL);
        push_byte("w");
        push_byte(CH_NUL);
      end else if (pick < 70) begin
        // well-formed line: blanks, then words built of plain and quoted runs
        repeat ($urandom_range(5)) begin
          repeat ($urandom_range(2, 1)) push_byte(blank_byte());
          repeat ($urandom_range(3, 1)) begin
            if ($urandom_range(2) == 0) begin
              qc = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
              push_byte(qc);
              repeat ($urandom_range(5)) push_byte(text_byte(qc, 1'b0));
              push_byte(qc);
            end else begin
              repeat ($urandom_range(5, 1)) push_byte(text_byte(CH_NUL, 1'b1));
            end
          end
        end
        if ($urandom_range(1)) push_byte(blank_byte());
        push_byte(CH_NUL);
      end else if (pick < 88) begin
        // noise: any nonzero bytes, quotes may stay open
        repeat ($urandom_range(12, 1)) push_byte(text_byte(CH_NUL, 1'b0));
        push_byte(CH_NUL);
      end else begin
        // broken line: a quote left open at line end
        repeat ($urandom_range(3)) push_byte(text_byte(CH_NUL, 1'b1));
        push_byte($urandom_range(1) ? CH_DQUOTE : CH_SQUOTE);
        repeat ($urandom_range(4)) push_byte(blank_byte());
        push_byte(CH_NUL);
      end
    end
  endtask

  // expected results are queued at input acceptance, checked at output acceptance
  always @(posedge clk_i) begin : scoreboard
    row_t   row;
    token_t t0;
    token_t t1;
    token_t want;
    int     n;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        row = line_bytes[accepted];
        accepted++;
        n = tokenize_byte(row.ch, t0, t1);
        if (row.typed) begin
          n  = row.n_typed;
          t0 = row.t0;
          t1 = row.t1;
        end
        if (n > 0) pending_tokens.push_back(t0);
        if (n > 1) pending_tokens.push_back(t1);
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_tokens.size() == 0) begin
          $error("unexpected result: kind %0d char %0h count %0d last %0d",
                 kind_o, char_out_o, arg_count_o, last_o);
          fail_count++;
        end else begin
          want = pending_tokens.pop_front();
          if (kind_o !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind_o);
            fail_count++;
          end
          if (char_out_o !== want.ch) begin
            $error("char_out: expected %0h, actual %0h", want.ch, char_out_o);
            fail_count++;
          end
          if (arg_count_o !== want.count) begin
            $error("arg_count: expected %0d, actual %0d", want.count, arg_count_o);
            fail_count++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last_o);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("quoted_command_line_tokenizer_top_tb failed");
      $finish;
    end
  end

  // receiver: random stalls, none while calm, one long hold on request
  initial begin : output_side
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 29);
      end
    end
  end

  // entered at a falling edge, leaves at a falling edge after acceptance
  task automatic send_byte(input logic [7:0] c);
    while (!calm && !hold_req && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : input_side
    int hold_at;
    int pause_at;
    int calm_lo;
    int calm_hi;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    char_in_i  = '0;
    skip_blanks = 1'b1;
    quote_open  = Q_NONE;
    args_seen   = '0;
    foreach (DIRECTED_ROWS[i]) line_bytes.push_back(DIRECTED_ROWS[i]);
    build_lines();
    hold_at  = N_DIRECTED + 200;
    pause_at = N_DIRECTED + 550;
    calm_lo  = N_DIRECTED + 700;
    calm_hi  = N_DIRECTED + 850;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < line_bytes.size(); i++) begin
      if (i == pause_at) begin
        // sender waits until the block has drained completely
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (pending_tokens.size() != 0) @(negedge clk_i);
      end
      if (i == hold_at) hold_req = 1'b1;
      calm = (i >= calm_lo) && (i < calm_hi);
      send_byte(line_bytes[i].ch);
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("quoted_command_line_tokenizer_top_tb passed");
    end else begin
      $display("quoted_command_line_tokenizer_top_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
